[src/sm3_pkg.sv]
// Shared constants, types and helper functions for the SM3 hash engine.
`timescale 1ns / 1ps

package sm3_pkg;

   localparam int WORD_W       = 32;
   localparam int BLOCK_WORDS  = 16;
   localparam int DIGEST_WORDS = 8;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;

   // Round constants, and the high constant pre-rotated for round sixteen
   localparam logic [WORD_W-1:0] T_LOW        = 32'h79cc4519;
   localparam logic [WORD_W-1:0] T_HIGH       = 32'h7a879d8a;
   localparam logic [WORD_W-1:0] T_HIGH_ROT16 = {T_HIGH[15:0], T_HIGH[31:16]};

   localparam logic [7:0]        PAD_BYTE = 8'h80;
   localparam logic [WORD_W-1:0] PAD_WORD = {PAD_BYTE, 24'h000000};

   // Position of the first length word within a block
   localparam logic [3:0] LEN_SLOT = 4'd14;

   localparam logic [WORD_W-1:0] SM3_IV [DIGEST_WORDS] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   // One block word on its way from the front to the compression unit
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              msg_end;
   } q_entry_type;

   typedef enum logic [2:0] {
      F_TAKE,
      F_PADW,
      F_ZERO,
      F_LENHI,
      F_LENLO
   } front_state_type;

   typedef enum logic [1:0] {
      B_LOAD,
      B_ROUND,
      B_FOLD,
      B_EMIT
   } back_state_type;

   // Rotate left; n is always a constant in 1..31 at the call sites
   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
      rotl = (x << n) | (x >> (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] perm0(input logic [WORD_W-1:0] x);
      perm0 = x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic logic [WORD_W-1:0] perm1(input logic [WORD_W-1:0] x);
      perm1 = x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

endpackage

[src/sm3_chan_if.sv]
// Valid/ready channel interfaces for message words and digest words.
`timescale 1ns / 1ps

interface sm3_req_if import sm3_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_word;
   logic [2:0]        valid_bytes;
   logic              last_word;

   modport source (output valid, output data_word, output valid_bytes, output last_word,
                   input ready);
   modport sink   (input valid, input data_word, input valid_bytes, input last_word,
                   output ready);
endinterface

interface sm3_rsp_if import sm3_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] digest_word;
   logic [2:0]        digest_index;
   logic              digest_last;

   modport source (output valid, output digest_word, output digest_index,
                   output digest_last, input ready);
   modport sink   (input valid, input digest_word, input digest_index,
                   input digest_last, output ready);
endinterface

[src/sm3_front.sv]
// Front end: takes message transactions, counts bits and emits padded block words.
`timescale 1ns / 1ps

module sm3_front import sm3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sm3_req_if.sink      req_if,
   output logic         push_valid,
   output q_entry_type  push_entry,
   input  logic         push_ready
);

   front_state_type   state_ff, state_in;
   logic [3:0]        fill_ff, fill_in;
   logic [63:0]       count_ff, count_in;

   logic [2:0]        valid_clamp;
   logic [5:0]        shift_bits;
   logic [WORD_W-1:0] keep_mask;
   logic [WORD_W-1:0] tail_word;
   logic              take;
   logic              push_fire;

   // Clamp the byte count and build the last partial word with its pad byte
   always_comb begin
      valid_clamp = (req_if.valid_bytes inside {[3'd4:3'd7]}) ? 3'd4 : req_if.valid_bytes;
      shift_bits  = {valid_clamp, 3'b000};
      keep_mask   = ~({WORD_W{1'b1}} >> shift_bits);
      tail_word   = (req_if.data_word & keep_mask) | (PAD_WORD >> shift_bits);
   end

   // Drive the handshakes and the word for the current state
   always_comb begin
      req_if.ready       = 1'b0;
      push_valid         = 1'b0;
      push_entry.word    = '0;
      push_entry.msg_end = 1'b0;
      case (state_ff)
         F_TAKE: begin
            req_if.ready    = push_ready;
            push_valid      = req_if.valid;
            push_entry.word = (!req_if.last_word || valid_clamp == 3'd4) ?
                              req_if.data_word : tail_word;
         end
         F_PADW: begin
            push_valid      = 1'b1;
            push_entry.word = PAD_WORD;
         end
         F_ZERO: begin
            push_valid = (fill_ff != LEN_SLOT);
         end
         F_LENHI: begin
            push_valid      = 1'b1;
            push_entry.word = count_ff[63:32];
         end
         F_LENLO: begin
            push_valid         = 1'b1;
            push_entry.word    = count_ff[31:0];
            push_entry.msg_end = 1'b1;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   assign take      = req_if.valid && req_if.ready;
   assign push_fire = push_valid && push_ready;

   // Walk through pad, zero fill and length words after the last transaction
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_TAKE: begin
            if (take && req_if.last_word) begin
               state_in = (valid_clamp == 3'd4) ? F_PADW : F_ZERO;
            end
         end
         F_PADW: begin
            if (push_fire) state_in = F_ZERO;
         end
         F_ZERO: begin
            if (fill_ff == LEN_SLOT) state_in = F_LENHI;
         end
         F_LENHI: begin
            if (push_fire) state_in = F_LENLO;
         end
         F_LENLO: begin
            if (push_fire) state_in = F_TAKE;
         end
         default: begin
            state_in = F_TAKE;
         end
      endcase
   end

   // Advance the block fill and the message bit count
   always_comb begin
      fill_in  = push_fire ? fill_ff + 4'd1 : fill_ff;
      count_in = count_ff;
      if (take) begin
         count_in = count_ff + (req_if.last_word ? 64'(shift_bits) : 64'd32);
      end else if (state_ff == F_LENLO && push_fire) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_TAKE;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/sm3_queue.sv]
// Short word queue between the front end and the compression unit.
`timescale 1ns / 1ps

module sm3_queue import sm3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  q_entry_type  push_entry,
   output logic         push_ready,
   output logic         pop_valid,
   output q_entry_type  pop_entry,
   input  logic         pop_ready
);

   q_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   level_ff, level_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (level_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push_fire && !pop_fire) level_in = level_ff + (QPTR_W+1)'(1);
      if (!push_fire && pop_fire) level_in = level_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push_fire) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

[src/sm3_back.sv]
// Back end: loads block words, runs the 64 compression rounds and emits the digest.
`timescale 1ns / 1ps

module sm3_back import sm3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   input  q_entry_type  pop_entry,
   output logic         pop_ready,
   sm3_rsp_if.source    rsp_if
);

   back_state_type    state_ff, state_in;
   logic [WORD_W-1:0] chain_ff [DIGEST_WORDS];
   logic [WORD_W-1:0] win_ff [BLOCK_WORDS];
   logic [WORD_W-1:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [WORD_W-1:0] t_ff;
   logic [3:0]        load_cnt_ff;
   logic [5:0]        round_ff;
   logic              end_ff;
   logic [2:0]        idx_ff;

   logic              pop_fire;
   logic              rsp_fire;
   logic              block_full;
   logic              first_half;
   logic [WORD_W-1:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, w_next;

   // Handshakes and registered digest output
   always_comb begin
      pop_ready           = (state_ff == B_LOAD);
      rsp_if.valid        = (state_ff == B_EMIT);
      rsp_if.digest_word  = chain_ff[0];
      rsp_if.digest_index = idx_ff;
      rsp_if.digest_last  = (idx_ff == 3'(DIGEST_WORDS - 1));
   end

   assign pop_fire   = pop_valid && pop_ready;
   assign rsp_fire   = rsp_if.valid && rsp_if.ready;
   assign block_full = pop_fire && (load_cnt_ff == 4'(BLOCK_WORDS - 1));

   // One compression round and one message expansion step
   always_comb begin
      first_half = (round_ff[5:4] == 2'b00);
      a12    = rotl(a_ff, 12);
      ss1    = rotl(a12 + e_ff + t_ff, 7);
      ss2    = ss1 ^ a12;
      ffv    = first_half ? (a_ff ^ b_ff ^ c_ff) :
                            ((a_ff & b_ff) | (a_ff & c_ff) | (b_ff & c_ff));
      ggv    = first_half ? (e_ff ^ f_ff ^ g_ff) : ((e_ff & f_ff) | (~e_ff & g_ff));
      tt1    = ffv + d_ff + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2    = ggv + h_ff + ss1 + win_ff[0];
      w_next = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 15)) ^
               rotl(win_ff[3], 7) ^ win_ff[10];
   end

   // Sequence load, rounds, fold and digest output
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_LOAD: begin
            if (block_full) state_in = B_ROUND;
         end
         B_ROUND: begin
            if (round_ff == 6'd63) state_in = B_FOLD;
         end
         B_FOLD: begin
            state_in = end_ff ? B_EMIT : B_LOAD;
         end
         B_EMIT: begin
            if (rsp_fire && rsp_if.digest_last) state_in = B_LOAD;
         end
         default: begin
            state_in = B_LOAD;
         end
      endcase
   end

   // Control and chaining value
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_LOAD;
         load_cnt_ff <= '0;
         round_ff    <= '0;
         end_ff      <= 1'b0;
         idx_ff      <= '0;
         for (int k = 0; k < DIGEST_WORDS; k++) chain_ff[k] <= SM3_IV[k];
      end else begin
         state_ff <= state_in;
         if (pop_fire) begin
            load_cnt_ff <= load_cnt_ff + 4'd1;
            if (block_full) begin
               end_ff   <= pop_entry.msg_end;
               round_ff <= '0;
            end
         end
         if (state_ff == B_ROUND) round_ff <= round_ff + 6'd1;
         if (state_ff == B_FOLD) begin
            chain_ff[0] <= chain_ff[0] ^ a_ff;
            chain_ff[1] <= chain_ff[1] ^ b_ff;
            chain_ff[2] <= chain_ff[2] ^ c_ff;
            chain_ff[3] <= chain_ff[3] ^ d_ff;
            chain_ff[4] <= chain_ff[4] ^ e_ff;
            chain_ff[5] <= chain_ff[5] ^ f_ff;
            chain_ff[6] <= chain_ff[6] ^ g_ff;
            chain_ff[7] <= chain_ff[7] ^ h_ff;
         end
         // Shift the digest out, then return to the IV
         if (rsp_fire) begin
            idx_ff <= idx_ff + 3'd1;
            if (rsp_if.digest_last) begin
               for (int k = 0; k < DIGEST_WORDS; k++) chain_ff[k] <= SM3_IV[k];
            end else begin
               for (int k = 0; k < DIGEST_WORDS - 1; k++) chain_ff[k] <= chain_ff[k+1];
            end
         end
      end
   end

   // Message window and working variables
   always_ff @(posedge clock) begin
      if (pop_fire || state_ff == B_ROUND) begin
         for (int k = 0; k < BLOCK_WORDS - 1; k++) win_ff[k] <= win_ff[k+1];
         win_ff[BLOCK_WORDS-1] <= pop_fire ? pop_entry.word : w_next;
      end
      if (block_full) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
         f_ff <= chain_ff[5];
         g_ff <= chain_ff[6];
         h_ff <= chain_ff[7];
         t_ff <= T_LOW;
      end else if (state_ff == B_ROUND) begin
         d_ff <= c_ff;
         c_ff <= rotl(b_ff, 9);
         b_ff <= a_ff;
         a_ff <= tt1;
         h_ff <= g_ff;
         g_ff <= rotl(f_ff, 19);
         f_ff <= e_ff;
         e_ff <= perm0(tt2);
         t_ff <= (round_ff == 6'd15) ? T_HIGH_ROT16 : rotl(t_ff, 1);
      end
   end

endmodule

[src/sm3_hash_engine.sv]
// Top level of the SM3 hash engine: front end, word queue and compression unit.
//
// The engine hashes a message streamed in as big-endian 32-bit words; the word marked
// last may carry 0 to 4 valid leading bytes, and all other words are taken whole.
// After the last word it returns the 256-bit digest as eight transactions, index 0
// first, and starts over from the IV. While the queue has room and the front end is not
// closing a message, it takes one word per cycle into a four-entry queue; the compression
// unit drains the queue at one word per cycle, then runs the 64 rounds (one round per
// cycle) and folds the chaining value before it loads the next block. Closing a message
// adds up to 18 padding and length words generated by the front end, one or two extra
// blocks, and the eight digest transactions.
`timescale 1ns / 1ps

module sm3_hash_engine import sm3_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sm3_req_if.sink   req_if,
   sm3_rsp_if.source rsp_if
);

   logic        push_valid;
   logic        push_ready;
   q_entry_type push_entry;
   logic        pop_valid;
   logic        pop_ready;
   q_entry_type pop_entry;

   sm3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   sm3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   sm3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

   // No block words are drained while the digest is going out
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !pop_ready)
      else $error("queue drained during digest output");

   // A digest always starts at index 0
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> (rsp_if.digest_index == 3'd0))
      else $error("digest did not start at index 0");

   // The final digest word ends the output burst
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.digest_last) |=> !rsp_if.valid)
      else $error("digest output continued past the last word");

endmodule

[bench/sm3_digest_checker.sv]
// Digest checker: tracks message words, predicts SM3 digests and compares them.
`timescale 1ns / 1ps

module sm3_digest_checker import sm3_pkg::*; (
   input  logic clock,
   input  logic reset,
   sm3_req_if   req_if,
   sm3_rsp_if   rsp_if,
   output int   fail_count,
   output int   words_pending
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   // Predicted hash state
   bit [31:0]       chain [8];
   bit [31:0]       blk [16];
   bit [63:0]       msg_bits;
   int unsigned     fill;
   digest_beat_type digest_due [$];

   function automatic bit [31:0] rotl32(input bit [31:0] x, input int unsigned n);
      int unsigned s;
      s = n % 32;
      if (s == 0)
         return x;
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic bit [31:0] mix0(input bit [31:0] x);
      return x ^ rotl32(x, 9) ^ rotl32(x, 17);
   endfunction

   function automatic bit [31:0] mix1(input bit [31:0] x);
      return x ^ rotl32(x, 15) ^ rotl32(x, 23);
   endfunction

   function automatic void restart_chain();
      for (int k = 0; k < 8; k++)
         chain[k] = SM3_IV[k];
      msg_bits = '0;
      fill = 0;
   endfunction

   // Run the 64 rounds over the gathered block and fold into the chain
   function automatic void fold_block();
      bit [31:0] w [68];
      bit [31:0] a, b, c, d, e, f, g, h;
      bit [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
      int j;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (j = 0; j < 16; j++)
         w[j] = blk[j];
      for (j = 16; j < 68; j++)
         w[j] = mix1(w[j-16] ^ w[j-9] ^ rotl32(w[j-3], 15)) ^ rotl32(w[j-13], 7) ^ w[j-6];
      for (j = 0; j < 64; j++) begin
         tj  = (j < 16) ? T_LOW : T_HIGH;
         a12 = rotl32(a, 12);
         ss1 = rotl32(a12 + e + rotl32(tj, j), 7);
         ss2 = ss1 ^ a12;
         ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
         gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
         tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + h + ss1 + w[j];
         d = c; c = rotl32(b, 9); b = a; a = tt1;
         h = g; g = rotl32(f, 19); f = e; e = mix0(tt2);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
   endfunction

   function automatic void take_word(input bit [31:0] w);
      blk[fill] = w;
      fill++;
      if (fill == 16) begin
         fold_block();
         fill = 0;
      end
   endfunction

   // Apply one accepted message word; on the last word pad, close and queue the digest
   function automatic void absorb_request(input bit [31:0] data, input bit [2:0] nb_in,
                                          input bit is_last);
      int unsigned     nb;
      bit [31:0]       w;
      digest_beat_type beat;
      if (!is_last) begin
         msg_bits += 32;
         take_word(data);
         return;
      end
      nb = (nb_in > 4) ? 4 : nb_in;
      msg_bits += 8 * nb;
      if (nb == 4) begin
         take_word(data);
         take_word({PAD_BYTE, 24'h000000});
      end else begin
         w = '0;
         if (nb > 0)
            w = data & (32'hffffffff << (32 - 8 * nb));
         w |= {PAD_BYTE, 24'h000000} >> (8 * nb);
         take_word(w);
      end
      // No room for the length: zero out this block and start another
      if (fill > 14)
         while (fill != 0)
            take_word('0);
      while (fill < 14)
         take_word('0);
      take_word(msg_bits[63:32]);
      take_word(msg_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
         beat.word  = chain[k];
         beat.index = 3'(k);
         beat.last  = (k == 7);
         digest_due.push_back(beat);
      end
      restart_chain();
   endfunction

   initial begin
      fail_count    = 0;
      words_pending = 0;
      restart_chain();
   end

   // Watch both channels at each rising edge
   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         restart_chain();
         digest_due.delete();
      end else begin
         if (req_if.valid && req_if.ready)
            absorb_request(req_if.data_word, req_if.valid_bytes, req_if.last_word);
         if (rsp_if.valid && rsp_if.ready) begin
            if (digest_due.size() == 0) begin
               $display("%0t: unexpected digest transaction word %h index %0d last %0b",
                        $time, rsp_if.digest_word, rsp_if.digest_index, rsp_if.digest_last);
               fail_count++;
            end else begin
               want = digest_due.pop_front();
               if (rsp_if.digest_word !== want.word) begin
                  $display("%0t: digest_word expected %h actual %h", $time, want.word,
                           rsp_if.digest_word);
                  fail_count++;
               end
               if (rsp_if.digest_index !== want.index) begin
                  $display("%0t: digest_index expected %0d actual %0d", $time, want.index,
                           rsp_if.digest_index);
                  fail_count++;
               end
               if (rsp_if.digest_last !== want.last) begin
                  $display("%0t: digest_last expected %0b actual %0b", $time, want.last,
                           rsp_if.digest_last);
                  fail_count++;
               end
            end
         end
      end
      words_pending <= digest_due.size();
   end

endmodule

[bench/sm3_hash_engine_test.sv]
// Top of the SM3 hash engine testbench: clock, reset, message stimulus and verdict.
`timescale 1ns / 1ps

module sm3_hash_engine_test;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_pending;
   bit   steady_send;

   sm3_req_if req_if ();
   sm3_rsp_if rsp_if ();

   sm3_hash_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   sm3_digest_checker digest_check (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one message word, idling at random first, and hold it until taken
   task automatic put_word(input logic [31:0] w, input logic [2:0] nb, input logic lw);
      while (!steady_send && $urandom_range(0, 99) < 29) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_word   <= w;
      req_if.valid_bytes <= nb;
      req_if.last_word   <= lw;
      do
         @(posedge clock);
      while (!req_if.ready);
   endtask

   // Random content; full words mostly, with a random valid count now and then
   task automatic send_message(input int unsigned n_words);
      logic [31:0] w;
      logic [2:0]  nb;
      for (int unsigned i = 0; i < n_words; i++) begin
         case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom();
         endcase
         nb = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
         if (i == n_words - 1)
            nb = 3'($urandom_range(0, 7));
         put_word(w, nb, i == n_words - 1);
      end
   endtask

   // Receiver: random stalls, one long hold-off to back up the engine, a clean run, then random stalls again
   initial begin
      int unsigned tick;
      tick = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick >= 400 && tick < 1000)
            rsp_if.ready <= 1'b0;
         else if (tick >= 1000 && tick < 1800)
            rsp_if.ready <= 1'b1;
         else
            rsp_if.ready <= ($urandom_range(0, 99) >= 29);
      end
   end

   initial begin
      int unsigned sent;
      int unsigned n;
      int unsigned pick;
      int unsigned k;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.data_word   <= '0;
      req_if.valid_bytes <= '0;
      req_if.last_word   <= 1'b0;
      steady_send = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty message; the unused bytes carry ones that must be dropped
      put_word(32'hffffffff, 3'd0, 1'b1);
      // "abc" with junk in the fourth byte
      put_word(32'h616263ff, 3'd3, 1'b1);
      // Valid counts above four act as four
      put_word(32'hffffffff, 3'd7, 1'b1);
      put_word(32'h00000000, 3'd5, 1'b1);
      // Partial count on a word that is not last is ignored
      put_word(32'h00000000, 3'd1, 1'b0);
      put_word(32'hffffffff, 3'd2, 1'b1);
      // Fourteen words: the pad lands in slot 14, so the length needs a second block
      for (int i = 0; i < 13; i++)
         put_word((i % 2) ? 32'hffffffff : 32'h00000000, (i == 4) ? 3'd0 : 3'd4, 1'b0);
      put_word(32'h61626364, 3'd4, 1'b1);
      put_word(32'h12345678, 3'd1, 1'b1);
      put_word(32'h9abcdef0, 3'd6, 1'b1);

      // Random messages, one run of them without sender gaps
      sent = 0;
      k = 0;
      while (sent < 100) begin
         steady_send = (k >= 3 && k < 6);
         pick = $urandom_range(0, 9);
         if (pick < 2)
            n = 1;
         else if (pick < 6)
            n = $urandom_range(2, 12);
         else if (pick < 8)
            n = $urandom_range(13, 17);
         else if (pick == 8)
            n = $urandom_range(29, 34);
         else
            n = $urandom_range(1, 4);
         send_message(n);
         sent += n;
         k++;
      end
      steady_send = 1'b0;
      req_if.valid <= 1'b0;

      // Let the checker count the final transaction, drain the digests, then watch for strays
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
src/sm3_pkg.sv
src/sm3_chan_if.sv
src/sm3_front.sv
src/sm3_queue.sv
src/sm3_back.sv
src/sm3_hash_engine.sv
bench/sm3_digest_checker.sv
bench/sm3_hash_engine_test.sv
